// ===== rtl/i2cms_pkg.sv =====
package i2cms_pkg;

    // sizes
    localparam int DEFAULT_DEPTH = 16;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 5;
    localparam int WIDE_W        = 9;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [IDX_W-1:0] IDX_MAX = 5'd31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd2;

    // bus status codes
    localparam logic [BYTE_W-1:0] ST_START        = 8'h08;
    localparam logic [BYTE_W-1:0] ST_REP_START    = 8'h10;
    localparam logic [BYTE_W-1:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [BYTE_W-1:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [BYTE_W-1:0] ST_ARB_LOST     = 8'h38;
    localparam logic [BYTE_W-1:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [BYTE_W-1:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [BYTE_W-1:0] ST_MR_DATA_NACK = 8'h58;

    typedef enum logic [1:0] {
        MODE_HOST_WR,
        MODE_HOST_RD,
        MODE_BEGIN,
        MODE_BUS_EVENT
    } mode_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SEND,
        CMD_STOP,
        CMD_START,
        CMD_RACK,
        CMD_RNACK,
        CMD_RESET
    } cmd_t;

    // result of one request, buffer data merged in after the registered buffer read
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] tx_fix;
        logic              tx_mem;
        logic              rd_mem;
        logic              busy;
        logic              err;
        logic [BYTE_W-1:0] err_status;
    } result_t;

endpackage

// ===== rtl/i2cms_buf_mem.sv =====
module i2cms_buf_mem
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_DEPTH,
    parameter int ADDR_W       = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/i2cms_seq.sv =====
module i2cms_seq
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_DEPTH,
    parameter int ADDR_W       = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mode_t             mode,
    input  logic [3:0]        slot,
    input  logic [BYTE_W-1:0] host_byte,
    input  logic [BYTE_W-1:0] bus_status,
    input  logic [BYTE_W-1:0] received_byte,
    input  logic [BYTE_W-1:0] address_byte,
    input  logic              read_not_write,
    input  logic [IDX_W-1:0]  transfer_length,
    output logic              wr_en,
    output logic [ADDR_W-1:0] waddr,
    output logic [BYTE_W-1:0] wdata,
    output logic              rd_en,
    output logic [ADDR_W-1:0] raddr,
    output result_t           result
);

    localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(BUFFER_DEPTH);

    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic              busy_reg, busy_next;
    logic              err_reg, err_next;
    logic [BYTE_W-1:0] saved_reg, saved_next;

    logic [WIDE_W-1:0] slot_w;
    logic [WIDE_W-1:0] idx_w;
    logic [WIDE_W-1:0] len_w;
    logic [WIDE_W-1:0] eff_len;
    logic [IDX_W-1:0]  idx_bumped;
    logic [WIDE_W-1:0] bumped_plus1;
    logic [WIDE_W-1:0] idx_plus1;

    // widened operands for compares against the depth
    always_comb
    begin
        slot_w       = WIDE_W'(slot);
        idx_w        = WIDE_W'(byte_index_reg);
        len_w        = WIDE_W'(transfer_length);
        eff_len      = (len_w > DEPTH_W) ? DEPTH_W : len_w;
        idx_bumped   = (byte_index_reg < IDX_MAX) ? byte_index_reg + 1'b1 : byte_index_reg;
        bumped_plus1 = WIDE_W'(idx_bumped) + 1'b1;
        idx_plus1    = idx_w + 1'b1;
    end

    // request decode and state update
    always_comb
    begin
        byte_index_next = byte_index_reg;
        busy_next       = busy_reg;
        err_next        = err_reg;
        saved_next      = saved_reg;
        wr_en           = 1'b0;
        waddr           = slot_w[ADDR_W-1:0];
        wdata           = host_byte;
        rd_en           = 1'b0;
        raddr           = slot_w[ADDR_W-1:0];
        result.cmd      = CMD_NONE;
        result.tx_fix   = '0;
        result.tx_mem   = 1'b0;
        result.rd_mem   = 1'b0;

        if (accept)
        begin
            unique case (mode)
                MODE_HOST_WR:
                begin
                    wr_en = (slot_w < DEPTH_W);
                end
                MODE_HOST_RD:
                begin
                    rd_en         = (slot_w < DEPTH_W);
                    result.rd_mem = (slot_w < DEPTH_W);
                end
                MODE_BEGIN:
                begin
                    if (!busy_reg)
                    begin
                        busy_next  = 1'b1;
                        result.cmd = CMD_START;
                    end
                end
                MODE_BUS_EVENT:
                begin
                    if (busy_reg)
                    begin
                        unique case (bus_status) inside
                            ST_START, ST_REP_START:
                            begin
                                result.tx_fix   = {address_byte[BYTE_W-1:1], read_not_write};
                                byte_index_next = '0;
                                result.cmd      = CMD_SEND;
                            end
                            ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                            begin
                                if (idx_w < eff_len)
                                begin
                                    rd_en           = 1'b1;
                                    raddr           = idx_w[ADDR_W-1:0];
                                    result.tx_mem   = 1'b1;
                                    byte_index_next = idx_bumped;
                                    result.cmd      = CMD_SEND;
                                end
                                else
                                begin
                                    busy_next  = 1'b0;
                                    result.cmd = CMD_STOP;
                                end
                            end
                            ST_MR_DATA_ACK:
                            begin
                                wr_en           = (idx_w < DEPTH_W);
                                waddr           = idx_w[ADDR_W-1:0];
                                wdata           = received_byte;
                                byte_index_next = idx_bumped;
                                result.cmd      = (bumped_plus1 < eff_len) ? CMD_RACK : CMD_RNACK;
                            end
                            ST_MR_SLA_ACK:
                            begin
                                result.cmd = (idx_plus1 < eff_len) ? CMD_RACK : CMD_RNACK;
                            end
                            ST_MR_DATA_NACK:
                            begin
                                wr_en      = (idx_w < DEPTH_W);
                                waddr      = idx_w[ADDR_W-1:0];
                                wdata      = received_byte;
                                busy_next  = 1'b0;
                                result.cmd = CMD_STOP;
                            end
                            ST_ARB_LOST:
                            begin
                                result.cmd = CMD_START;
                            end
                            default:
                            begin
                                saved_next = bus_status;
                                err_next   = 1'b1;
                                busy_next  = 1'b0;
                                result.cmd = CMD_RESET;
                            end
                        endcase
                    end
                end
                default:
                begin
                    result.cmd = CMD_NONE;
                end
            endcase
        end

        result.busy       = busy_next;
        result.err        = err_next;
        result.err_status = saved_next;
    end

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            busy_reg       <= 1'b0;
            err_reg        <= 1'b0;
            saved_reg      <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            busy_reg       <= busy_next;
            err_reg        <= err_next;
            saved_reg      <= saved_next;
        end
    end

endmodule

// ===== rtl/i2c_master_transfer_sequencer_unit.sv =====
// a result passes through the s1 stage register and then the output register once its request is accepted
// throughput: one request per cycle while m_tready does not stall the output, set by the single buffer
// memory port pair (at most one write or one registered read per request) and a one-entry output register
// reset: control state, transfer index, flags and configuration clear to zero;
// buffer contents stay undefined until written
module i2c_master_transfer_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // slot, host_byte, bus_status, received_byte
    input  logic [1:0]            s_tuser,  // mode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // command, transmit_byte, read_data, busy_res,
                                            // error_seen, error_status
);

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [BYTE_W-1:0] address_reg;
    logic              dir_reg;
    logic [IDX_W-1:0]  length_reg;

    logic              accept;
    logic              s1_valid_reg;
    result_t           s1_res_reg;
    logic              s1_move;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic [BYTE_W-1:0] rdata;
    result_t           result;

    logic [BYTE_W-1:0] tx_byte;
    logic [BYTE_W-1:0] rd_byte;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= '0;
            dir_reg     <= 1'b0;
            length_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ADDRESS)
            begin
                address_reg <= cfg_data;
            end
            if (cfg_index == CFG_DIR)
            begin
                dir_reg <= cfg_data[0];
            end
            if (cfg_index == CFG_LENGTH)
            begin
                length_reg <= cfg_data[IDX_W-1:0];
            end
        end
    end

    // handshake and stage movement
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    i2cms_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .mode            (mode_t'(s_tuser)),
        .slot            (s_tdata[3:0]),
        .host_byte       (s_tdata[11:4]),
        .bus_status      (s_tdata[19:12]),
        .received_byte   (s_tdata[27:20]),
        .address_byte    (address_reg),
        .read_not_write  (dir_reg),
        .transfer_length (length_reg),
        .wr_en           (wr_en),
        .waddr           (waddr),
        .wdata           (wdata),
        .rd_en           (rd_en),
        .raddr           (raddr),
        .result          (result)
    );

    i2cms_buf_mem #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_buf (
        .clk   (clk),
        .wr_en (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .rd_en (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // merge buffer read data into the result word
    always_comb
    begin
        tx_byte       = s1_res_reg.tx_mem ? rdata : s1_res_reg.tx_fix;
        rd_byte       = s1_res_reg.rd_mem ? rdata : '0;
        out_data_next = {3'b000, s1_res_reg.err_status, s1_res_reg.err, s1_res_reg.busy,
                         rd_byte, tx_byte, s1_res_reg.cmd};
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= result;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
